[src/pida_pkg.sv]
package pida_pkg;

	// Request codes (s_tuser)
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Result status codes (m_tuser)
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Controller states: output register empty / holding a word
	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_HOLD = 1'b1
	} fsm_t;

	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int FILL_W  = 5;

	// Command from controller to datapath
	typedef struct packed {
		logic exec;
		op_t  op;
	} cmd_t;

endpackage

[src/pida_ctrl.sv]
module pida_ctrl
	import pida_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] s_tuser,
	output logic       m_tvalid,
	input  logic       m_tready,
	output cmd_t       cmd
);

	fsm_t state_q;
	fsm_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b1;
		m_tvalid = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				m_tvalid = 1'b0;
				if (s_tvalid) begin
					state_d = FSM_HOLD;
				end
			end
			FSM_HOLD: begin
				// output word drains while the next request loads
				m_tvalid = 1'b1;
				s_tready = m_tready;
				if (m_tready && !s_tvalid) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
		cmd.exec = s_tvalid && s_tready;
		cmd.op   = op_t'(s_tuser);
	end

endmodule

[src/pida_dp.sv]
module pida_dp
	import pida_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	input  logic [POS_W-1:0]          position,
	input  logic signed [VALUE_W-1:0] new_value,
	output status_t                   status,
	output logic signed [VALUE_W-1:0] read_value,
	output logic [FILL_W-1:0]         fill_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic signed [VALUE_W-1:0] entries_q [CAPACITY];
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic [PW-1:0]             pos_w;
	logic [PW-1:0]             cnt_w;
	logic [PW-1:0]             pos_m1;
	logic                      full;
	logic                      empty;
	status_t                   st;
	logic                      ok;
	logic signed [VALUE_W-1:0] rd_val;

	assign pos_w  = {{(PW-POS_W){1'b0}}, position};
	assign cnt_w  = {{(PW-CW){1'b0}}, count_q};
	assign pos_m1 = pos_w - PW'(1);
	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);

	always_comb begin
		st      = ST_BADPOS;
		count_d = count_q;
		unique case (cmd.op) inside
			OP_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
					st = ST_BADPOS;
				end else begin
					st      = ST_OK;
					count_d = count_q + CW'(1);
				end
			end
			OP_DELETE, OP_READ: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					st = ST_BADPOS;
				end else begin
					st = ST_OK;
					if (cmd.op == OP_DELETE) begin
						count_d = count_q - CW'(1);
					end
				end
			end
			default: begin
				st = ST_BADPOS;
			end
		endcase
		ok = (st == ST_OK);
		rd_val = '0;
		if (ok && cmd.op == OP_READ) begin
			rd_val = entries_q[pos_m1[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// One cell per entry; shift up on insert, down on delete
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int PREV = (i == 0) ? 0 : i - 1;
		localparam int NEXT = (i == CAPACITY - 1) ? i : i + 1;
		always_ff @(posedge clk) begin
			if (cmd.exec && ok) begin
				if (cmd.op == OP_INSERT) begin
					if (PW'(i) == pos_m1) begin
						entries_q[i] <= new_value;
					end else if (PW'(i) > pos_m1) begin
						entries_q[i] <= entries_q[PREV];
					end
				end else if (cmd.op == OP_DELETE) begin
					if (PW'(i) >= pos_m1 && i < CAPACITY - 1) begin
						entries_q[i] <= entries_q[NEXT];
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status     <= st;
			read_value <= rd_val;
			fill_count <= FILL_W'(count_d);
		end
	end

endmodule

[src/positional_insert_delete_array_top.sv]
// Positional insert/delete array: CAPACITY signed 32-bit entries with a fill count.
// Slave channel (s_*) takes one request word: s_tuser is the request kind
// (insert, delete, read), s_tdata carries the 1-based position and the value.
// Master channel (m_*) returns one result word per request: m_tuser is the
// status (ok, full, empty, bad position), m_tdata the read value and fill count.
// The result is registered and valid the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes results; every entry
// is its own register and the whole row shifts together.
// A failed request leaves entries and count unchanged.
// The output register lets the next request in while a result is being taken;
// when the receiver stalls with a result held, s_tready drops until m_tready.
// Reset (arst_n low) empties the array and drops m_tvalid; entry contents are
// left as they are, only positions below the fill count are ever read.
module positional_insert_delete_array_top
	import pida_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [4:0] position, [36:5] new_value, [39:37] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] read_value, [36:32] fill_count, [39:37] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	cmd_t                      cmd;
	status_t                   status;
	logic signed [VALUE_W-1:0] read_value;
	logic [FILL_W-1:0]         fill_count;

	// handshake and sequencing
	pida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// entry row, count and result register
	pida_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.position   (s_tdata[POS_W-1:0]),
		.new_value  (s_tdata[POS_W+VALUE_W-1:POS_W]),
		.status     (status),
		.read_value (read_value),
		.fill_count (fill_count)
	);

	assign m_tdata = {3'b000, fill_count, read_value};
	assign m_tuser = status;

endmodule

[sim/pida_checker.sv]
module pida_checker
	import pida_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [4:0] position, [36:5] new_value, [39:37] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [31:0] read_value, [36:32] fill_count, [39:37] zero
	input  logic [1:0]  m_tuser,   // [1:0] status
	output int          fail_count,
	output int          waiting,
	output int          fill_now,
	output int          n_checked,
	output int          n_full,
	output int          n_empty,
	output int          n_badpos
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t             st;
		logic [VALUE_W-1:0]  rd;
		logic [FILL_W-1:0]   fill;
	} result_t;

	logic [VALUE_W-1:0] slots [CAPACITY];
	int                 fill = 0;
	result_t            pending_results [$];

	int fails    = 0;
	int depth    = 0;
	int checked  = 0;
	int full_cnt = 0;
	int empty_cnt = 0;
	int bad_cnt  = 0;

	assign fail_count = fails;
	assign waiting    = depth;
	assign fill_now   = fill;
	assign n_checked  = checked;
	assign n_full     = full_cnt;
	assign n_empty    = empty_cnt;
	assign n_badpos   = bad_cnt;

	// full / empty checked ahead of the position range
	function automatic result_t apply_request(op_t op, int unsigned pos,
			logic [VALUE_W-1:0] val);
		result_t r;
		r.st = ST_OK;
		r.rd = '0;
		case (op)
			OP_INSERT: begin
				if (fill >= CAPACITY) begin
					r.st = ST_FULL;
				end else if (pos < 1 || pos > fill + 1) begin
					r.st = ST_BADPOS;
				end else begin
					for (int i = fill; i >= int'(pos); i--)
						slots[i] = slots[i-1];
					slots[pos-1] = val;
					fill++;
				end
			end
			OP_DELETE: begin
				if (fill == 0) begin
					r.st = ST_EMPTY;
				end else if (pos < 1 || pos > fill) begin
					r.st = ST_BADPOS;
				end else begin
					for (int i = pos - 1; i + 1 < fill; i++)
						slots[i] = slots[i+1];
					fill--;
				end
			end
			OP_READ: begin
				if (fill == 0) begin
					r.st = ST_EMPTY;
				end else if (pos < 1 || pos > fill) begin
					r.st = ST_BADPOS;
				end else begin
					r.rd = slots[pos-1];
				end
			end
			default: r.st = ST_BADPOS;
		endcase
		r.fill = FILL_W'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			fill = 0;
			pending_results.delete();
		end else begin
			// results are registered and come later than their request, so drain first
			if (m_tvalid && m_tready) begin
				got.st   = status_t'(m_tuser);
				got.rd   = m_tdata[31:0];
				got.fill = m_tdata[36:32];
				checked++;
				if (pending_results.size() == 0) begin
					if (fails < 10)
						$display("%0t: result word with nothing pending: st=%0d rd=%h fill=%0d",
							$realtime, got.st, got.rd, got.fill);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st || got.rd !== want.rd ||
							got.fill !== want.fill || m_tdata[39:37] !== 3'b000) begin
						if (fails < 10)
							$display("%0t: mismatch st exp %0d got %0d, rd exp %h got %h, fill exp %0d got %0d, pad %b",
								$realtime, want.st, got.st, want.rd, got.rd,
								want.fill, got.fill, m_tdata[39:37]);
						fails++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_request(op_t'(s_tuser), s_tdata[4:0], s_tdata[36:5]);
				case (want.st)
					ST_FULL:   full_cnt++;
					ST_EMPTY:  empty_cnt++;
					ST_BADPOS: bad_cnt++;
					default: ;
				endcase
				pending_results.push_back(want);
			end
		end
		depth = pending_results.size();
	end

endmodule

[sim/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pida_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int N_RANDOM    = 550;
	localparam int PHASE_LEN   = 64;      // items per grow / shrink phase
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;    // [4:0] position, [36:5] new_value, [39:37] zero
	logic [1:0]  s_tuser  = '0;    // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // [31:0] read_value, [36:32] fill_count, [39:37] zero
	logic [1:0]  m_tuser;          // [1:0] status

	// registered at the rising edge, read at the falling edge: no race with the DUT
	logic s_fire = 1'b0;

	int fail_count, waiting, fill_now, n_checked, n_full, n_empty, n_badpos;
	int n_sent   = 0;
	int cycles   = 0;
	int op_cnt [4];
	bit calm     = 1'b0;   // no idling on either side while set

	positional_insert_delete_array_top #(
		.CAPACITY (CAPACITY)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	pida_checker #(
		.CAPACITY (CAPACITY)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.waiting    (waiting),
		.fill_now   (fill_now),
		.n_checked  (n_checked),
		.n_full     (n_full),
		.n_empty    (n_empty),
		.n_badpos   (n_badpos)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[positional_insert_delete_array_top] ERROR");
			$finish;
		end
	end

	// receiver: stalls about 28% of cycles, never during the calm stretch
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(99) >= 28);
	end

	// Present one request word and hold it until accepted. Entered and left at a
	// falling edge; s_tvalid is left high so back-to-back words need no gap.
	task automatic send_word(input op_t op, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] val);
		while (!calm && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, val, pos};
		do @(negedge clk); while (!s_fire);
		op_cnt[op]++;
		n_sent++;
		calm = (n_sent >= 250 && n_sent < 350);
	endtask

	initial begin
		int   k;
		int   roll;
		int   hi;
		bit   grow;
		op_t  op;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;

		foreach (op_cnt[i]) op_cnt[i] = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed: empty array, bad positions, edges of the row ---
		send_word(OP_READ,   5'd1,  32'h0000_1234);   // read on empty
		send_word(OP_DELETE, 5'd1,  32'h0);           // delete on empty
		send_word(OP_READ,   5'd0,  32'h0);           // empty wins over position zero
		send_word(OP_NONE,   5'd31, 32'hFFFF_FFFF);   // unused code
		send_word(OP_INSERT, 5'd0,  32'h5555_5555);   // position zero
		send_word(OP_INSERT, 5'd2,  32'hAAAA_AAAA);   // beyond count+1
		send_word(OP_INSERT, 5'd1,  32'h8000_0000);   // most negative
		send_word(OP_INSERT, 5'd2,  32'h7FFF_FFFF);   // most positive, append
		send_word(OP_INSERT, 5'd1,  32'h0000_0000);   // at the front
		send_word(OP_INSERT, 5'd3,  32'hFFFF_FFFF);   // in the middle
		send_word(OP_READ,   5'd1,  32'h0);
		send_word(OP_READ,   5'd2,  32'h0);
		send_word(OP_READ,   5'd3,  32'h0);
		send_word(OP_READ,   5'd4,  32'h0);
		send_word(OP_READ,   5'd5,  32'h0);           // one past the end
		send_word(OP_READ,   5'd31, 32'h0);           // top of the position field
		send_word(OP_DELETE, 5'd0,  32'h0);
		send_word(OP_DELETE, 5'd5,  32'h0);
		send_word(OP_DELETE, 5'd2,  32'h0);           // middle
		send_word(OP_DELETE, 5'd3,  32'h0);           // last
		send_word(OP_DELETE, 5'd1,  32'h0);           // first
		send_word(OP_READ,   5'd1,  32'h0);
		send_word(OP_DELETE, 5'd1,  32'h0);           // back to empty
		send_word(OP_NONE,   5'd0,  32'h0);

		// --- random: alternate grow and shrink phases so the row fills and drains ---
		for (k = 0; k < N_RANDOM; k++) begin
			grow = ((k / PHASE_LEN) % 2) == 0;
			roll = $urandom_range(99);
			if (roll < 8) begin
				// noise: any code, any position
				op  = op_t'($urandom_range(3));
				pos = POS_W'($urandom_range(31));
				val = $urandom;
			end else begin
				roll = $urandom_range(99);
				if (roll < 60)
					op = grow ? OP_INSERT : OP_DELETE;
				else if (roll < 85)
					op = OP_READ;
				else
					op = grow ? OP_DELETE : OP_INSERT;
				// fill_now is current: the checker updated it at the accepting edge
				hi = (op == OP_INSERT) ? fill_now + 1 : ((fill_now > 0) ? fill_now : 1);
				if ($urandom_range(99) < 85)
					pos = POS_W'($urandom_range(hi, 1));
				else
					pos = POS_W'($urandom_range(31));
				case ($urandom_range(7))
					0: val = 32'h8000_0000;
					1: val = 32'h7FFF_FFFF;
					2: val = 32'hFFFF_FFFF;
					default: val = $urandom;
				endcase
			end
			send_word(op, pos, val);
		end
		s_tvalid <= 1'b0;

		// drain, then keep watching for any stray word
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("Ran %0d requests: %0d insert, %0d delete, %0d read, %0d unused; %0d results checked.",
			n_sent, op_cnt[OP_INSERT], op_cnt[OP_DELETE], op_cnt[OP_READ], op_cnt[OP_NONE],
			n_checked);
		$display("Rejections seen: %0d full, %0d empty, %0d bad position.",
			n_full, n_empty, n_badpos);
		if (fail_count == 0) begin
			$display("[positional_insert_delete_array_top] OK");
		end else begin
			$display("[positional_insert_delete_array_top] ERROR");
		end
		$finish;
	end

endmodule

[files.f]
src/pida_pkg.sv
src/pida_ctrl.sv
src/pida_dp.sv
src/positional_insert_delete_array_top.sv
sim/pida_checker.sv
sim/testbench.sv
